@@ rtl/hcu_pkg.sv @@
// Shared types and constants for the Huffman tree codec unit.
// Used by hcu_ctrl, hcu_datapath and huffman_tree_codec_unit; depends on nothing.
`default_nettype none
package hcu_pkg;

   localparam int COUNT_W  = 40;
   localparam int SYM_W    = 8;
   localparam int FREQ_W   = 32;
   localparam int CODE_W   = 64;
   localparam int CODE_IW  = 6;
   localparam int LEN_W    = 7;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 88;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_BUILD,
      OP_ENCODE,
      OP_DECODE
   } op_type;

   typedef enum logic [1:0] {
      KIND_BUILD,
      KIND_CODE,
      KIND_SYMBOL
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_TREE,
      ST_ABSENT
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_QINIT,
      S_SCAN_A,
      S_SCAN_B,
      S_NODE,
      S_PARB,
      S_ECHK,
      S_EPAR,
      S_ECHILD,
      S_DCHK,
      S_DSEL,
      S_DPOST,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_LOAD,
      CMD_BINIT,
      CMD_QINIT,
      CMD_QEND,
      CMD_SCAN,
      CMD_TAKE_A,
      CMD_TAKE_B,
      CMD_NODE,
      CMD_PARB,
      CMD_ROOT,
      CMD_ESTART,
      CMD_EPAR,
      CMD_ECHILD,
      CMD_ESTEP,
      CMD_DSTART,
      CMD_DREAD,
      CMD_DSEL,
      CMD_DPARK,
      CMD_DLEAF,
      CMD_RESULT
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      status_type   status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   tree_valid;
      logic   sym_absent;
      logic   qinit_done;
      logic   scan_done;
      logic   best_found;
      logic   next_full;
      logic   cur_is_root;
      logic   len_full;
      logic   par_bad;
      logic   cur_is_leaf;
      logic   out_free;
   } flags_type;

   function automatic kind_type op_to_kind(input op_type op);
      kind_type k;
      unique case (op)
         OP_BUILD:  k = KIND_BUILD;
         OP_ENCODE: k = KIND_CODE;
         default:   k = KIND_SYMBOL;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

@@ rtl/hcu_ctrl.sv @@
// Controller state machine of the Huffman tree codec unit.
// Depends on hcu_pkg; drives commands into hcu_datapath and reads its flags.
`default_nettype none
module hcu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire hcu_pkg::flags_type  flags,
   output hcu_pkg::cmd_type         cmd
);
   import hcu_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd.code   = CMD_NONE;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.code = CMD_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (flags.op)
               OP_LOAD: begin
                  cmd.code = CMD_LOAD;
                  state_in = S_IDLE;
               end
               OP_BUILD: begin
                  cmd.code = CMD_BINIT;
                  state_in = S_QINIT;
               end
               OP_ENCODE: begin
                  priority if (!flags.tree_valid) begin
                     status_in = ST_NO_TREE;
                     state_in  = S_DONE;
                  end else if (flags.sym_absent) begin
                     status_in = ST_ABSENT;
                     state_in  = S_DONE;
                  end else begin
                     cmd.code = CMD_ESTART;
                     state_in = S_ECHK;
                  end
               end
               default: begin
                  if (!flags.tree_valid) begin
                     status_in = ST_NO_TREE;
                     state_in  = S_DONE;
                  end else begin
                     cmd.code = CMD_DSTART;
                     state_in = S_DCHK;
                  end
               end
            endcase
         end
         S_QINIT: begin
            if (flags.qinit_done) begin
               cmd.code = CMD_QEND;
               state_in = S_SCAN_A;
            end else begin
               cmd.code = CMD_QINIT;
            end
         end
         S_SCAN_A: begin
            priority if (!flags.scan_done) begin
               cmd.code = CMD_SCAN;
            end else if (flags.best_found) begin
               cmd.code = CMD_TAKE_A;
               state_in = S_SCAN_B;
            end else begin
               status_in = ST_NO_TREE;
               state_in  = S_DONE;
            end
         end
         S_SCAN_B: begin
            priority if (!flags.scan_done) begin
               cmd.code = CMD_SCAN;
            end else if (flags.best_found && !flags.next_full) begin
               cmd.code = CMD_TAKE_B;
               state_in = S_NODE;
            end else begin
               cmd.code  = CMD_ROOT;
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_NODE: begin
            cmd.code = CMD_NODE;
            state_in = S_PARB;
         end
         S_PARB: begin
            cmd.code = CMD_PARB;
            state_in = S_SCAN_A;
         end
         S_ECHK: begin
            priority if (flags.cur_is_root) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else if (flags.len_full) begin
               status_in = ST_ABSENT;
               state_in  = S_DONE;
            end else begin
               cmd.code = CMD_EPAR;
               state_in = S_EPAR;
            end
         end
         S_EPAR: begin
            if (flags.par_bad) begin
               status_in = ST_ABSENT;
               state_in  = S_DONE;
            end else begin
               cmd.code = CMD_ECHILD;
               state_in = S_ECHILD;
            end
         end
         S_ECHILD: begin
            cmd.code = CMD_ESTEP;
            state_in = S_ECHK;
         end
         S_DCHK: begin
            if (flags.cur_is_leaf) begin
               cmd.code  = CMD_DLEAF;
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               cmd.code = CMD_DREAD;
               state_in = S_DSEL;
            end
         end
         S_DSEL: begin
            cmd.code = CMD_DSEL;
            state_in = S_DPOST;
         end
         S_DPOST: begin
            if (flags.cur_is_leaf) begin
               cmd.code  = CMD_DLEAF;
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               cmd.code = CMD_DPARK;
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (flags.out_free) begin
               cmd.code = CMD_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/hcu_datapath.sv @@
// Datapath of the Huffman tree codec unit: node memories, scan comparator,
// encode climb, decode walk and the result register. Depends on hcu_pkg.
`default_nettype none
module hcu_datapath #(
   parameter int NUM_SYMBOLS  = 256,
   parameter int MAX_CODE_LEN = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [hcu_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic [1:0]                 req_tuser,
   input  wire hcu_pkg::cmd_type           cmd,
   output hcu_pkg::flags_type              flags,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [1:0]                      rsp_tuser,
   output logic [hcu_pkg::RSP_W-1:0]       rsp_tdata
);
   import hcu_pkg::*;

   localparam int Slots = 2 * NUM_SYMBOLS - 1;
   localparam int NodeW = $clog2(Slots);
   localparam int SymW  = $clog2(NUM_SYMBOLS);

   op_type                   op_ff;
   logic [SYM_W-1:0]         sym_ff;
   logic [FREQ_W-1:0]        freq_ff;
   logic                     bit_ff;

   logic [NUM_SYMBOLS-1:0]   leaf_nz_ff;
   logic                     queue_mem [Slots];

   logic [SYM_W+COUNT_W-1:0] node_mem [Slots];
   logic [NodeW-1:0]         parent_mem [Slots];
   logic [2*NodeW-1:0]       child_mem [Slots];
   logic [SYM_W+COUNT_W-1:0] node_rd_ff;
   logic [NodeW-1:0]         parent_rd_ff;
   logic [2*NodeW-1:0]       child_rd_ff;

   logic [NodeW-1:0]         next_ff, scan_idx_ff, rd_idx_ff;
   logic                     rd_valid_ff, rd_inq_ff;
   logic                     best_found_ff;
   logic [NodeW-1:0]         best_idx_ff;
   logic [COUNT_W-1:0]       best_count_ff;
   logic [SYM_W-1:0]         best_sym_ff;
   logic [NodeW-1:0]         a_idx_ff;
   logic [COUNT_W-1:0]       a_count_ff;
   logic [SYM_W-1:0]         a_sym_ff;

   logic [NodeW-1:0]         root_ff, cursor_ff, cur_ff;
   logic                     tree_valid_ff;
   logic [LEN_W-1:0]         len_ff;
   logic [CODE_W-1:0]        code_ff;
   logic [SYM_W-1:0]         dsym_ff;

   logic                     rsp_valid_ff;
   kind_type                 rsp_kind_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   logic                     sym_ok;
   logic [NodeW-1:0]         sym_node;
   logic                     scan_rd;
   logic [COUNT_W-1:0]       rd_count;
   logic [SYM_W-1:0]         rd_sym;
   logic                     outranks;
   logic [NodeW-1:0]         dec_start, dec_next, dec_pick;
   logic                     par_we;
   logic [NodeW-1:0]         par_waddr;
   logic [NodeW-1:0]         child_raddr;
   logic                     q_we;
   logic [NodeW-1:0]         q_waddr;
   logic                     q_wdata;
   logic                     ok_result;
   logic [CODE_W-1:0]        res_code;
   logic [LEN_W-1:0]         res_len;
   logic [SYM_W-1:0]         res_sym;

   assign sym_ok   = ({1'b0, sym_ff} < (SYM_W+1)'(NUM_SYMBOLS));
   assign sym_node = NodeW'(sym_ff);
   assign scan_rd  = (cmd.code == CMD_SCAN) && (scan_idx_ff < next_ff);
   assign rd_count = node_rd_ff[COUNT_W-1:0];
   assign rd_sym   = node_rd_ff[SYM_W+COUNT_W-1:COUNT_W];
   assign outranks = !best_found_ff || (rd_count < best_count_ff) ||
                     ((rd_count == best_count_ff) && (rd_sym > best_sym_ff));

   assign dec_start = (cursor_ff >= NodeW'(Slots)) ? root_ff : cursor_ff;
   assign dec_pick  = bit_ff ? child_rd_ff[2*NodeW-1:NodeW] : child_rd_ff[NodeW-1:0];
   assign dec_next  = (dec_pick >= NodeW'(Slots)) ? root_ff : dec_pick;

   assign flags.op          = op_ff;
   assign flags.tree_valid  = tree_valid_ff;
   assign flags.sym_absent  = !sym_ok || !leaf_nz_ff[sym_ff[SymW-1:0]];
   assign flags.qinit_done  = (scan_idx_ff >= NodeW'(NUM_SYMBOLS));
   assign flags.scan_done   = (scan_idx_ff >= next_ff) && !rd_valid_ff;
   assign flags.best_found  = best_found_ff;
   assign flags.next_full   = (next_ff >= NodeW'(Slots));
   assign flags.cur_is_root = (cur_ff == root_ff);
   assign flags.len_full    = (len_ff >= LEN_W'(MAX_CODE_LEN));
   assign flags.par_bad     = (parent_rd_ff >= NodeW'(Slots));
   assign flags.cur_is_leaf = (cur_ff < NodeW'(NUM_SYMBOLS));
   assign flags.out_free    = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.code == CMD_ACCEPT) begin
         op_ff   <= op_type'(req_tuser);
         sym_ff  <= req_tdata[7:0];
         freq_ff <= req_tdata[39:8];
         bit_ff  <= req_tdata[40];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.code == CMD_LOAD && sym_ok) begin
         node_mem[sym_node] <= {sym_ff, COUNT_W'(freq_ff)};
      end else if (cmd.code == CMD_NODE) begin
         node_mem[next_ff] <= {a_sym_ff, a_count_ff + best_count_ff};
      end
      if (scan_rd) begin
         node_rd_ff <= node_mem[scan_idx_ff];
      end
   end

   always_comb begin
      q_we    = 1'b0;
      q_waddr = scan_idx_ff;
      q_wdata = 1'b0;
      unique case (cmd.code)
         CMD_QINIT: begin
            q_we    = 1'b1;
            q_waddr = scan_idx_ff;
            q_wdata = leaf_nz_ff[scan_idx_ff[SymW-1:0]];
         end
         CMD_TAKE_A, CMD_TAKE_B: begin
            q_we    = 1'b1;
            q_waddr = best_idx_ff;
            q_wdata = 1'b0;
         end
         CMD_NODE: begin
            q_we    = 1'b1;
            q_waddr = next_ff;
            q_wdata = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (scan_rd) begin
         rd_inq_ff <= queue_mem[scan_idx_ff];
      end
   end

   assign par_we    = (cmd.code == CMD_NODE) || (cmd.code == CMD_PARB);
   assign par_waddr = (cmd.code == CMD_NODE) ? a_idx_ff : best_idx_ff;

   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_waddr] <= next_ff;
      end
      if (cmd.code == CMD_EPAR) begin
         parent_rd_ff <= parent_mem[cur_ff];
      end
   end

   assign child_raddr = (cmd.code == CMD_ECHILD) ? parent_rd_ff : cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.code == CMD_NODE) begin
         child_mem[next_ff] <= {best_idx_ff, a_idx_ff};
      end
      if (cmd.code == CMD_ECHILD || cmd.code == CMD_DREAD) begin
         child_rd_ff <= child_mem[child_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_nz_ff    <= '0;
         tree_valid_ff <= 1'b0;
         root_ff       <= '0;
         cursor_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         next_ff       <= NodeW'(NUM_SYMBOLS);
         scan_idx_ff   <= '0;
      end else begin
         rd_valid_ff <= scan_rd;
         if (scan_rd) begin
            rd_idx_ff   <= scan_idx_ff;
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (rd_valid_ff && rd_inq_ff && outranks) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_count_ff <= rd_count;
            best_sym_ff   <= rd_sym;
         end
         unique case (cmd.code)
            CMD_LOAD: begin
               if (sym_ok) begin
                  leaf_nz_ff[sym_ff[SymW-1:0]] <= (freq_ff != '0);
                  tree_valid_ff <= 1'b0;
                  cursor_ff     <= '0;
               end
            end
            CMD_BINIT: begin
               tree_valid_ff <= 1'b0;
               next_ff       <= NodeW'(NUM_SYMBOLS);
               scan_idx_ff   <= '0;
               best_found_ff <= 1'b0;
            end
            CMD_QINIT: begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            CMD_QEND: begin
               scan_idx_ff   <= '0;
               best_found_ff <= 1'b0;
            end
            CMD_TAKE_A: begin
               a_idx_ff      <= best_idx_ff;
               a_count_ff    <= best_count_ff;
               a_sym_ff      <= best_sym_ff;
               scan_idx_ff   <= '0;
               best_found_ff <= 1'b0;
            end
            CMD_PARB: begin
               next_ff       <= next_ff + 1'b1;
               scan_idx_ff   <= '0;
               best_found_ff <= 1'b0;
            end
            CMD_ROOT: begin
               root_ff       <= a_idx_ff;
               cursor_ff     <= a_idx_ff;
               tree_valid_ff <= 1'b1;
            end
            CMD_DPARK: begin
               cursor_ff <= cur_ff;
            end
            CMD_DLEAF: begin
               cursor_ff <= root_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.code)
         CMD_ESTART: begin
            cur_ff  <= sym_node;
            len_ff  <= '0;
            code_ff <= '0;
         end
         CMD_ESTEP: begin
            if (child_rd_ff[2*NodeW-1:NodeW] == cur_ff) begin
               code_ff[len_ff[CODE_IW-1:0]] <= 1'b1;
            end
            len_ff <= len_ff + 1'b1;
            cur_ff <= parent_rd_ff;
         end
         CMD_DSTART: begin
            cur_ff <= dec_start;
         end
         CMD_DSEL: begin
            cur_ff <= dec_next;
         end
         CMD_DLEAF: begin
            dsym_ff <= SYM_W'(cur_ff);
         end
         default: begin
         end
      endcase
   end

   assign ok_result = (cmd.status == ST_OK);
   assign res_code  = (ok_result && op_ff == OP_ENCODE) ? code_ff : '0;
   assign res_len   = (ok_result && op_ff == OP_ENCODE) ?
                      ((len_ff == '0) ? LEN_W'(1) : len_ff) : '0;
   assign res_sym   = (ok_result && op_ff == OP_DECODE) ? dsym_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.code == CMD_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.code == CMD_RESULT) begin
         rsp_kind_ff <= op_to_kind(op_ff);
         rsp_data_ff <= {7'b0, cmd.status, res_sym, res_len, res_code};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ rtl/huffman_tree_codec_unit.sv @@
// Top level of the Huffman tree codec unit.
// Depends on hcu_pkg, hcu_ctrl and hcu_datapath.
`default_nettype none
// Requests carry the operation in req_tuser: load a symbol count, build the tree,
// encode a symbol or decode one bit. One request is handled at a time, and a result
// may wait in S_DONE for room on the response side.
// A build first copies the present-symbol flags into the queue memory, one leaf per
// cycle, then runs repeated minimum searches over the node memory through its single
// read port, one node per cycle: two searches per merge, each over the leaves and
// every node made so far. The result register lets a new request be taken while a
// result waits on the response side.
module huffman_tree_codec_unit #(
   parameter int NUM_SYMBOLS  = 256,
   parameter int MAX_CODE_LEN = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // req_tdata from bit 0: sym[7:0], freq[39:8], bit_in[40], zero fill.
   input  wire logic [hcu_pkg::REQ_W-1:0]  req_tdata,
   // req_tuser: op[1:0].
   input  wire logic [1:0]                 req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // rsp_tdata from bit 0: code_bits[63:0], code_length[70:64], sym_out[78:71],
   // status[80:79], zero fill.
   output logic [hcu_pkg::RSP_W-1:0]       rsp_tdata,
   // rsp_tuser: kind[1:0].
   output logic [1:0]                      rsp_tuser
);
   import hcu_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   hcu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   hcu_datapath #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   a_build_never_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BUILD |-> rsp_tdata[80:79] != ST_ABSENT)
      else $error("build result reports an absent symbol");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[80:79] != ST_OK |->
         rsp_tdata[78:0] == '0)
      else $error("error result carries non-zero fields");

   a_code_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CODE && rsp_tdata[80:79] == ST_OK |->
         rsp_tdata[70:64] != '0 && rsp_tdata[70:64] <= LEN_W'(MAX_CODE_LEN))
      else $error("code length out of range");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("load request produced a result");

endmodule
`default_nettype wire

@@ tb/huffman_tree_codec_unit_tb.sv @@
// Self-checking testbench for the Huffman tree codec unit: loads, builds, encodes and decodes
// are driven over the request stream and every response is checked against a built-in model.
// Depends on hcu_pkg and huffman_tree_codec_unit.
`default_nettype none
module huffman_tree_codec_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hcu_pkg::*;

   localparam int NSYM  = 256;
   localparam int SLOTS = 2 * NSYM - 1;
   localparam int NONE  = 1023;

   typedef struct {
      kind_type    kind;
      logic [63:0] code;
      logic [6:0]  len;
      logic [7:0]  sym;
      status_type  status;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   huffman_tree_codec_unit DUT (.*);

   // Model of the tree held by the block.
   logic [39:0] cnt [SLOTS];
   logic [7:0]  nsym [SLOTS];
   int          parent [SLOTS];
   int          child0 [SLOTS];
   int          child1 [SLOTS];
   bit          queued [SLOTS];
   int          root;
   bit          tree_ok;
   int          cursor;

   result_type pending_results [$];
   int errors = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit outranks(int a, int b);
      if (cnt[a] != cnt[b]) return cnt[a] < cnt[b];
      return nsym[a] > nsym[b];
   endfunction

   function automatic int take_best(int limit);
      int best;
      best = NONE;
      for (int i = 0; i < limit; i++)
         if (queued[i] && (best == NONE || outranks(i, best))) best = i;
      if (best != NONE) queued[best] = 0;
      return best;
   endfunction

   function automatic status_type build_tree();
      int nxt, a, b;
      nxt = NSYM;
      for (int i = 0; i < SLOTS; i++) begin
         if (i < NSYM) begin
            nsym[i] = i[7:0];
            queued[i] = cnt[i] != 0;
         end else begin
            queued[i] = 0;
         end
      end
      tree_ok = 0;
      forever begin
         a = take_best(nxt);
         if (a == NONE) return ST_NO_TREE;
         b = take_best(nxt);
         if (b == NONE || nxt >= SLOTS) begin
            root = a;
            tree_ok = 1;
            cursor = root;
            return ST_OK;
         end
         cnt[nxt] = cnt[a] + cnt[b];
         nsym[nxt] = nsym[a];
         child0[nxt] = a;
         child1[nxt] = b;
         parent[a] = nxt;
         parent[b] = nxt;
         queued[nxt] = 1;
         nxt++;
      end
   endfunction

   function automatic result_type code_of(logic [7:0] s);
      result_type r;
      int cur, par, len;
      r = '{KIND_CODE, '0, '0, '0, ST_OK};
      if (!tree_ok) begin
         r.status = ST_NO_TREE;
         return r;
      end
      if (cnt[s] == 0) begin
         r.status = ST_ABSENT;
         return r;
      end
      if (s == root) begin
         r.len = 1;
         return r;
      end
      cur = s;
      len = 0;
      while (cur != root) begin
         par = parent[cur];
         if (len >= 64 || par >= SLOTS) begin
            r = '{KIND_CODE, '0, '0, '0, ST_ABSENT};
            return r;
         end
         if (child1[par] == cur) r.code[len] = 1'b1;
         len++;
         cur = par;
      end
      r.len = len[6:0];
      return r;
   endfunction

   function automatic void predict(op_type op, logic [7:0] s, logic [31:0] f, logic b);
      result_type r;
      int cur;
      r = '{op_to_kind(op), '0, '0, '0, ST_OK};
      case (op)
         OP_LOAD: begin
            cnt[s] = {8'd0, f};
            tree_ok = 0;
            cursor = 0;
            return;
         end
         OP_BUILD: r.status = build_tree();
         OP_ENCODE: r = code_of(s);
         OP_DECODE: begin
            if (!tree_ok) begin
               r.status = ST_NO_TREE;
            end else begin
               cur = cursor;
               if (cur >= SLOTS) cur = root;
               if (cur >= NSYM) cur = b ? child1[cur] : child0[cur];
               if (cur >= SLOTS) cur = root;
               if (cur >= NSYM) begin
                  cursor = cur;
                  return;
               end
               r.sym = nsym[cur];
               cursor = root;
            end
         end
      endcase
      pending_results.push_back(r);
   endfunction

   task automatic send(op_type op, logic [7:0] s = 0, logic [31:0] f = 0, logic b = 0);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, b, f, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      predict(op, s, f, b);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic decode_code(logic [7:0] s);
      result_type c;
      c = code_of(s);
      if (c.status != ST_OK) return;
      for (int i = int'(c.len) - 1; i >= 0; i--) send(OP_DECODE, 0, 0, c.code[i]);
   endtask

   task automatic clear_counts();
      for (int i = 0; i < NSYM; i++)
         if (cnt[i] != 0) send(OP_LOAD, i[7:0], 0);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response kind=%0d", rsp_tuser);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_tuser != e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[63:0] != e.code) begin
               $error("code_bits: expected %h, got %h", e.code, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[70:64] != e.len) begin
               $error("code_length: expected %0d, got %0d", e.len, rsp_tdata[70:64]);
               errors++;
            end
            if (rsp_tdata[78:71] != e.sym) begin
               $error("sym_out: expected %0d, got %0d", e.sym, rsp_tdata[78:71]);
               errors++;
            end
            if (rsp_tdata[80:79] != e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_tdata[80:79]);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send(OP_ENCODE, 8'd5);
      send(OP_DECODE, 0, 0, 1'b1);
      send(OP_BUILD);
      send(OP_ENCODE, 8'd0);
      send(OP_LOAD, 8'd200, 32'd7);
      send(OP_BUILD);
      send(OP_ENCODE, 8'd200);
      send(OP_DECODE, 0, 0, 1'b0);
      send(OP_DECODE, 0, 0, 1'b1);
      send(OP_ENCODE, 8'd3);
      send(OP_LOAD, 8'd0, 32'hFFFF_FFFF);
      send(OP_LOAD, 8'd255, 32'hFFFF_FFFF);
      send(OP_LOAD, 8'd128, 32'd7);
      send(OP_BUILD);
      send(OP_ENCODE, 8'd0);
      send(OP_ENCODE, 8'd255);
      send(OP_ENCODE, 8'd200);
      send(OP_ENCODE, 8'd17);
      decode_code(8'd255);
      decode_code(8'd0);
      send(OP_LOAD, 8'd1, 32'd3);
      send(OP_DECODE, 0, 0, 1'b0);
      drain();
   endtask

   // Fibonacci counts on symbols 0 to 45 give a deep tree.
   task automatic test_deep_tree();
      logic [31:0] fa, fb, fn;
      clear_counts();
      fa = 1;
      fb = 1;
      for (int i = 0; i < 46; i++) begin
         send(OP_LOAD, i[7:0], fa);
         fn = fa + fb;
         fa = fb;
         fb = fn;
      end
      send(OP_BUILD);
      for (int i = 0; i < 46; i += 5) send(OP_ENCODE, i[7:0]);
      decode_code(8'd0);
      decode_code(8'd45);
      drain();
   endtask

   task automatic test_full_alphabet();
      clear_counts();
      for (int i = 0; i < NSYM; i++) send(OP_LOAD, i[7:0], 32'($urandom_range(1, 1000)));
      send(OP_BUILD);
      for (int i = 0; i < 8; i++) send(OP_ENCODE, 8'($urandom_range(255)));
      decode_code(8'($urandom_range(255)));
      drain();
   endtask

   task automatic test_random(int items);
      int stop, nset, r;
      logic [7:0] present [$];
      logic [7:0] s;
      logic [31:0] f;
      stop = items_sent + items;
      while (items_sent < stop) begin
         clear_counts();
         present.delete();
         nset = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(2, 12));
         for (int i = 0; i < nset; i++) begin
            s = 8'($urandom_range(255));
            r = int'($urandom_range(9));
            f = (r < 4) ? $urandom : (r < 9) ? 32'($urandom_range(1, 4)) : 32'd0;
            send(OP_LOAD, s, f);
            present.push_back(s);
         end
         send(OP_BUILD);
         for (int i = 0; i < 10; i++) begin
            r = int'($urandom_range(99));
            s = present[$urandom_range(present.size() - 1)];
            if (r < 35) send(OP_ENCODE, s);
            else if (r < 45) send(OP_ENCODE, 8'($urandom_range(255)));
            else if (r < 70) decode_code(s);
            else if (r < 95) send(OP_DECODE, 0, 0, 1'($urandom_range(1)));
            else send(OP_LOAD, 8'($urandom_range(255)), $urandom);
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      for (int i = 0; i < 15; i++) send(OP_ENCODE, 8'($urandom_range(255)));
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < SLOTS; i++) begin
         cnt[i] = 0;
         queued[i] = 0;
      end
      root = 0;
      tree_ok = 0;
      cursor = 0;
      test_directed();
      test_deep_tree();
      test_full_alphabet();
      test_backpressure();
      test_random(140);
      send_idle_pct = 66;
      test_random(140);
      send_idle_pct = 0;
      recv_stall_pct = 66;
      test_random(140);
      send_idle_pct = 19;
      recv_stall_pct = 19;
      test_random(140);
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
